[sv/flash_save_memory_controller_assert.svh]
// Assertion macros for the flash save-memory controller.
`ifndef FLASH_SAVE_MEMORY_CONTROLLER_ASSERT_SVH
`define FLASH_SAVE_MEMORY_CONTROLLER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, off during reset.
`define FSMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsmc check failed");
// Next-cycle implication, off during reset.
`define FSMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsmc check failed");
`else
`define FSMC_ASSERT_IMP(lbl, ante, cons)
`define FSMC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/fsmc_pkg.sv]
package fsmc_pkg;

  // Geometry
  localparam int PAGES_DEF  = 1024;
  localparam int PAGE_WORDS = 32;
  localparam int PBUF_AW    = 5;

  // Field widths
  localparam int OP_W   = 2;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 15;
  localparam int MODE_W = 3;

  // Operations
  localparam logic [OP_W-1:0] OP_CMD    = 2'd0;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd3;

  // Modes
  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STATUS = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd4;

  // Command bytes (top byte of the command word)
  localparam logic [7:0] CMD_EXEC     = 8'hD2;
  localparam logic [7:0] CMD_STATUS   = 8'hE1;
  localparam logic [7:0] CMD_READ     = 8'hF0;
  localparam logic [7:0] CMD_PAGE     = 8'h4B;
  localparam logic [7:0] CMD_ERASE    = 8'h78;
  localparam logic [7:0] CMD_WRITE    = 8'hB4;
  localparam logic [7:0] CMD_PAGE_PGM = 8'hA5;

  // Status words loaded by the status, read, erase and page-program commands
  localparam logic [63:0] STAT_STATUS = 64'h1111800100C2001E;
  localparam logic [63:0] STAT_READ   = 64'h11118004F0000000;
  localparam logic [63:0] STAT_ERASE  = 64'h1111800800C2001E;
  localparam logic [63:0] STAT_PGM    = 64'h1111800400C2001E;

endpackage

[sv/fsmc_if.sv]
// Request channel: one access to the controller.
interface fsmc_req_if;
  logic                              valid;
  logic                              ready;
  logic [fsmc_pkg::OP_W-1:0]         operation;
  logic [fsmc_pkg::DATA_W-1:0]       value;
  logic [fsmc_pkg::IDX_W-1:0]        word_index;

  modport source (output valid, operation, value, word_index, input ready);
  modport sink   (input valid, operation, value, word_index, output ready);
endinterface

// Response channel: one result per request.
interface fsmc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [fsmc_pkg::DATA_W-1:0]       read_data;
  logic                              error;
  logic [fsmc_pkg::MODE_W-1:0]       current_mode;

  modport source (output valid, read_data, error, current_mode, input ready);
  modport sink   (input valid, read_data, error, current_mode, output ready);
endinterface

[sv/flash_save_memory_controller.sv]
// Flash save-memory controller.
// req carries one access (command write, status read, data read, data write);
// rsp returns exactly one item per request: read data, error flag, mode after it.
// cfg_we/cfg_wdata set the read-only flag, which blocks erase and program.
// Results: command, status read and data write give their result at the edge
// they are accepted; a store read goes through the registered memory read
// port and the RDWAIT state first. Execute in erase or write mode walks the 32
// page words through the single store write port, then posts from DONE.
// Throughput: one item per cycle for simple items while the output register
// is free; no new item is taken while a page operation or store read runs.
// Reset: synchronous. After it the block sweeps the whole store to all ones
// and the page buffer to zeros, one word per cycle, with req.ready low; cfg
// writes are taken during the sweep.
// Stall: the result sits in an output register; a new item is accepted while
// it waits only if the receiver takes it in the same cycle. Otherwise req.ready
// stays low until the result is taken.
`include "flash_save_memory_controller_assert.svh"

module flash_save_memory_controller #(
  parameter int PAGES = fsmc_pkg::PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  fsmc_req_if.sink          req,
  fsmc_rsp_if.source        rsp,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  localparam int STORE_WORDS = PAGES * fsmc_pkg::PAGE_WORDS;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int PB_AW       = fsmc_pkg::PBUF_AW;
  localparam int DW          = fsmc_pkg::DATA_W;
  localparam int MW          = fsmc_pkg::MODE_W;

  typedef enum logic [2:0] {ST_SWEEP, ST_IDLE, ST_RDWAIT, ST_EXEC, ST_DONE} state_t;

  // Control and architectural state
  state_t            state;
  logic [AW-1:0]     sweep_cnt;
  logic [PB_AW:0]    cnt;
  logic              exec_erase;
  logic [MW-1:0]     mode;
  logic [63:0]       status_word;
  logic [15:0]       page_number;
  logic              read_only;

  // Result register
  logic              out_valid;
  logic [DW-1:0]     res_data;
  logic              res_err;
  logic [MW-1:0]     res_mode;

  // Memories
  logic [DW-1:0]     store [STORE_WORDS];
  logic [DW-1:0]     store_q;
  logic [DW-1:0]     pbuf [fsmc_pkg::PAGE_WORDS];
  logic [DW-1:0]     pbuf_q;

  // Handshake
  logic              out_free;
  logic              acc;
  logic              res_post;

  // Decode of the accepted item
  logic [7:0]        cmd_byte;
  logic              dec_err;
  logic [DW-1:0]     dec_data;
  logic [MW-1:0]     dec_mode;
  logic              dec_stat_ld;
  logic [63:0]       dec_stat;
  logic              dec_page_ld;
  logic              dec_exec;
  logic              dec_rd_store;
  logic              dec_pb_we;
  logic              page_bad;
  logic              idx_in_store;

  // Memory port controls
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [DW-1:0]     st_wdata;
  logic [AW-1:0]     st_raddr;
  logic              pb_we;
  logic [PB_AW-1:0]  pb_waddr;
  logic [DW-1:0]     pb_wdata;
  logic [PB_AW-1:0]  wr_k;
  logic [20:0]       exec_addr_w;
  logic [31:0]       idx_w;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign acc       = req.valid && req.ready;

  // Result register loads this cycle
  assign res_post = (acc && !dec_exec && !dec_rd_store)
                 || ((state == ST_RDWAIT || state == ST_DONE) && out_free);

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = res_data;
  assign rsp.error        = res_err;
  assign rsp.current_mode = res_mode;

  assign cmd_byte     = req.value[31:24];
  assign page_bad     = {1'b0, page_number} >= 17'(PAGES);
  assign idx_w        = 32'(req.word_index);
  assign idx_in_store = idx_w < 32'(STORE_WORDS);
  assign st_raddr     = idx_w[AW-1:0];

  // Decode one accepted item
  always_comb begin
    dec_err      = 1'b0;
    dec_data     = '0;
    dec_mode     = mode;
    dec_stat_ld  = 1'b0;
    dec_stat     = status_word;
    dec_page_ld  = 1'b0;
    dec_exec     = 1'b0;
    dec_rd_store = 1'b0;
    dec_pb_we    = 1'b0;
    unique case (req.operation)
      fsmc_pkg::OP_CMD: begin
        unique case (cmd_byte)
          fsmc_pkg::CMD_EXEC: begin
            dec_mode = fsmc_pkg::MODE_IDLE;
            if (mode == fsmc_pkg::MODE_ERASE || mode == fsmc_pkg::MODE_WRITE) begin
              if (page_bad) dec_err = 1'b1;
              else if (!read_only) dec_exec = 1'b1;
            end
          end
          fsmc_pkg::CMD_STATUS: begin
            dec_mode    = fsmc_pkg::MODE_STATUS;
            dec_stat_ld = 1'b1;
            dec_stat    = fsmc_pkg::STAT_STATUS;
          end
          fsmc_pkg::CMD_READ: begin
            dec_mode    = fsmc_pkg::MODE_READ;
            dec_stat_ld = 1'b1;
            dec_stat    = fsmc_pkg::STAT_READ;
          end
          fsmc_pkg::CMD_PAGE: dec_page_ld = 1'b1;
          fsmc_pkg::CMD_ERASE: begin
            dec_mode    = fsmc_pkg::MODE_ERASE;
            dec_stat_ld = 1'b1;
            dec_stat    = fsmc_pkg::STAT_ERASE;
          end
          fsmc_pkg::CMD_WRITE: dec_mode = fsmc_pkg::MODE_WRITE;
          fsmc_pkg::CMD_PAGE_PGM: begin
            dec_page_ld = 1'b1;
            dec_stat_ld = 1'b1;
            dec_stat    = fsmc_pkg::STAT_PGM;
          end
          default: dec_err = 1'b1;
        endcase
      end
      fsmc_pkg::OP_STATUS: dec_data = status_word[63:32];
      fsmc_pkg::OP_READ: begin
        if (mode == fsmc_pkg::MODE_READ) begin
          if (idx_in_store) dec_rd_store = 1'b1;
          else dec_err = 1'b1;
        end else if (mode == fsmc_pkg::MODE_STATUS) begin
          dec_data = req.word_index[0] ? status_word[31:0] : status_word[63:32];
        end else begin
          dec_err = 1'b1;
        end
      end
      fsmc_pkg::OP_WRITE: begin
        if (mode == fsmc_pkg::MODE_WRITE && idx_w < 32'(fsmc_pkg::PAGE_WORDS))
          dec_pb_we = 1'b1;
        else
          dec_err = 1'b1;
      end
      default: dec_err = 1'b1;
    endcase
  end

  // Memory port muxing: clearing sweep or page walk
  always_comb begin
    wr_k        = PB_AW'(cnt - (PB_AW+1)'(1));
    exec_addr_w = {page_number, wr_k};
    if (state == ST_SWEEP) begin
      st_we    = 1'b1;
      st_waddr = sweep_cnt;
      st_wdata = '1;
    end else begin
      st_we    = (state == ST_EXEC) && (cnt != '0);
      st_waddr = exec_addr_w[AW-1:0];
      st_wdata = exec_erase ? '1 : pbuf_q;
    end
    if (state == ST_SWEEP) begin
      pb_we    = 1'b1;
      pb_waddr = sweep_cnt[PB_AW-1:0];
      pb_wdata = '0;
    end else begin
      pb_we    = acc && dec_pb_we;
      pb_waddr = req.word_index[PB_AW-1:0];
      pb_wdata = req.value;
    end
  end

  // Flash store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (st_we) store[st_waddr] <= st_wdata;
    if (acc && dec_rd_store) store_q <= store[st_raddr];
  end

  // Page buffer: read walks with the exec counter
  always_ff @(posedge clk) begin
    if (pb_we) pbuf[pb_waddr] <= pb_wdata;
    pbuf_q <= pbuf[cnt[PB_AW-1:0]];
  end

  // Sequencer, architectural registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_cnt   <= '0;
      cnt         <= '0;
      exec_erase  <= 1'b0;
      mode        <= fsmc_pkg::MODE_IDLE;
      status_word <= '0;
      page_number <= '0;
      read_only   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) read_only <= cfg_wdata;
      if (rsp.ready && !res_post) out_valid <= 1'b0;
      unique case (state)
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + AW'(1);
          if (sweep_cnt == AW'(STORE_WORDS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (acc) begin
            mode <= dec_mode;
            if (dec_stat_ld) status_word <= dec_stat;
            if (dec_page_ld) page_number <= req.value[15:0];
            if (dec_exec) begin
              state      <= ST_EXEC;
              cnt        <= '0;
              exec_erase <= (mode == fsmc_pkg::MODE_ERASE);
            end else if (dec_rd_store) begin
              state <= ST_RDWAIT;
            end else begin
              out_valid <= 1'b1;
              res_data  <= dec_data;
              res_err   <= dec_err;
              res_mode  <= dec_mode;
            end
          end
        end
        ST_RDWAIT: begin
          if (out_free) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            res_data  <= store_q;
            res_err   <= 1'b0;
            res_mode  <= mode;
          end
        end
        ST_EXEC: begin
          cnt <= cnt + (PB_AW+1)'(1);
          if (cnt == (PB_AW+1)'(fsmc_pkg::PAGE_WORDS)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            res_data  <= '0;
            res_err   <= 1'b0;
            res_mode  <= mode;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `FSMC_ASSERT_IMP(a_no_result_in_sweep, state == ST_SWEEP, !out_valid)
  `FSMC_ASSERT_IMP(a_store_write_owner, st_we, state == ST_SWEEP || state == ST_EXEC)
  `FSMC_ASSERT_IMP(a_exec_mode_idle, state == ST_EXEC, mode == fsmc_pkg::MODE_IDLE)
  `FSMC_ASSERT_NEXT(a_read_waits, acc && dec_rd_store, state == ST_RDWAIT && !req.ready)

endmodule
